// ===== src/salc_pkg.sv =====
package salc_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_CMP,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic        valid;
		logic        dirty;
		logic [31:0] stamp;
	} line_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic tag_we;
	} mem_ctl_t;

	typedef struct packed {
		logic match;
		logic take;
		logic stop;
	} eval_t;

	localparam logic [1:0] CFG_OFFSET_BITS  = 2'd0;
	localparam logic [1:0] CFG_SET_BITS     = 2'd1;
	localparam logic [1:0] CFG_WAYS_IN_USE  = 2'd2;
	localparam logic [1:0] CFG_MISS_PENALTY = 2'd3;

	localparam logic [3:0]  RST_OFFSET_BITS  = 4'd5;
	localparam logic [3:0]  RST_SET_BITS     = 4'd4;
	localparam logic [3:0]  RST_WAYS_IN_USE  = 4'd2;
	localparam logic [15:0] RST_MISS_PENALTY = 16'd100;

	localparam logic [3:0] OFFSET_BITS_MAX = 4'd12;
	localparam logic [3:0] SET_BITS_MAX    = 4'd8;

	localparam logic [1:0] OUT_HIT         = 2'd0;
	localparam logic [1:0] OUT_CLEAN_MISS  = 2'd1;
	localparam logic [1:0] OUT_DIRTY_MISS  = 2'd2;

	localparam logic REQ_WRITE = 1'b1;

endpackage

// ===== src/salc_way_eval.sv =====
module salc_way_eval
	import salc_pkg::*;
(
	input  line_state_t rd_state,
	input  logic [31:0] rd_tag,
	input  logic [31:0] req_tag,
	input  logic        first_way,
	input  logic [31:0] vic_stamp,
	input  logic        vic_stop,
	output eval_t       ev
);

	always_comb begin
		ev.match = rd_state.valid && (rd_tag == req_tag);
		ev.take  = !vic_stop && (first_way || !rd_state.valid || (vic_stamp > rd_state.stamp));
		ev.stop  = !vic_stop && !rd_state.valid;
	end

endmodule

// ===== src/salc_line_mem.sv =====
module salc_line_mem
	import salc_pkg::*;
#(
	parameter int LINES  = 2048,
	parameter int LINE_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_ctl_t          ctl,
	input  logic [LINE_W-1:0] addr,
	input  line_state_t       wr_state,
	input  logic [31:0]       wr_tag,
	output line_state_t       rd_state,
	output logic [31:0]       rd_tag,
	output logic              clearing
);

	line_state_t       state_mem [LINES];
	logic [31:0]       tag_mem [LINES];
	line_state_t       rd_state_q;
	logic [31:0]       rd_tag_q;
	logic              clr_active_q;
	logic [LINE_W-1:0] clr_addr_q;
	logic              st_we;
	logic [LINE_W-1:0] st_wa;
	line_state_t       st_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == LINE_W'(LINES - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_comb begin
		st_we = clr_active_q || ctl.wr_en;
		st_wa = clr_active_q ? clr_addr_q : addr;
		st_wd = clr_active_q ? '0 : wr_state;
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			state_mem[st_wa] <= st_wd;
		end
		if (ctl.rd_en) begin
			rd_state_q <= state_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tag_we) begin
			tag_mem[addr] <= wr_tag;
		end
		if (ctl.rd_en) begin
			rd_tag_q <= tag_mem[addr];
		end
	end

	assign rd_state = rd_state_q;
	assign rd_tag   = rd_tag_q;
	assign clearing = clr_active_q;

endmodule

// ===== src/set_assoc_cache_lru_model.sv =====
// Channel   Handshake               Payload
// request   start / busy            req_type, address, access_stamp
// result    done (one cycle)        set_index .. bytes_written_back
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request passes ST_REDUCE (repeated while the set wraps past MAX_SETS, never when
// MAX_SETS is 256 or more), then ST_READ and ST_CMP per way in use, then ST_UPDATE:
// the ways go one at a time through one line memory read port and one comparator.
// After reset a clear pass over all MAX_SETS*MAX_WAYS lines (2048 by default) holds busy.
// done rises the cycle busy falls; the receiver cannot stall, results are never held.
module set_assoc_cache_lru_model
	import salc_pkg::*;
#(
	parameter int MAX_WAYS     = 8,
	parameter int MAX_SETS     = 256,
	parameter int ADDRESS_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] address,
	input  logic [31:0] access_stamp,
	output logic        done,
	output logic [7:0]  set_index,
	output logic [31:0] tag_value,
	output logic [2:0]  way_chosen,
	output logic [1:0]  outcome,
	output logic [31:0] old_tag,
	output logic        old_valid,
	output logic        old_dirty,
	output logic [31:0] old_stamp,
	output logic [16:0] access_cycles,
	output logic [12:0] bytes_fetched,
	output logic [12:0] bytes_written_back,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LINES   = MAX_SETS * MAX_WAYS;
	localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
	localparam int MS_W    = $clog2(MAX_SETS + 1);
	localparam int CMP_W   = (MS_W > 8) ? MS_W : 8;
	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);

	state_t state_q, state_d;

	logic [3:0]  offset_bits_q;
	logic [3:0]  set_bits_q;
	logic [3:0]  ways_in_use_q;
	logic [15:0] miss_penalty_q;

	logic              is_write_q;
	logic [31:0]       stamp_q;
	logic [7:0]        set_q;
	logic [31:0]       tag_q;
	logic [3:0]        b_q;
	logic [WCNT_W-1:0] nw_q;
	logic [LINE_W-1:0] base_q;
	logic [WCNT_W-1:0] way_q;

	logic              hit_q;
	logic [WAY_W-1:0]  hit_way_q;
	logic              hit_dirty_q;
	logic [31:0]       hit_stamp_q;
	logic              vic_stop_q;
	logic [WAY_W-1:0]  vic_way_q;
	logic              vic_valid_q;
	logic              vic_dirty_q;
	logic [31:0]       vic_stamp_q;
	logic [31:0]       vic_tag_q;

	logic              done_q;
	logic [7:0]        set_index_q;
	logic [31:0]       tag_value_q;
	logic [2:0]        way_chosen_q;
	logic [1:0]        outcome_q;
	logic [31:0]       old_tag_q;
	logic              old_valid_q;
	logic              old_dirty_q;
	logic [31:0]       old_stamp_q;
	logic [16:0]       access_cycles_q;
	logic [12:0]       bytes_fetched_q;
	logic [12:0]       bytes_written_back_q;

	logic              clearing;
	logic              accept;
	logic              set_wraps;
	logic              last_way;
	mem_ctl_t          mem_ctl;
	logic [LINE_W-1:0] mem_addr;
	logic [WAY_W-1:0]  final_way;
	line_state_t       wr_state;
	line_state_t       rd_state;
	logic [31:0]       rd_tag;
	eval_t             ev;

	logic [3:0]        b_in;
	logic [3:0]        s_in;
	logic [5:0]        sb_in;
	logic [31:0]       addr_m;
	logic [7:0]        set_mask;
	logic [WCNT_W-1:0] nw_in;
	logic [12:0]       block_bytes;

	salc_line_mem #(
		.LINES  (LINES),
		.LINE_W (LINE_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.addr     (mem_addr),
		.wr_state (wr_state),
		.wr_tag   (tag_q),
		.rd_state (rd_state),
		.rd_tag   (rd_tag),
		.clearing (clearing)
	);

	salc_way_eval u_eval (
		.rd_state  (rd_state),
		.rd_tag    (rd_tag),
		.req_tag   (tag_q),
		.first_way (way_q == '0),
		.vic_stamp (vic_stamp_q),
		.vic_stop  (vic_stop_q),
		.ev        (ev)
	);

	assign busy      = clearing || (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q  <= RST_OFFSET_BITS;
			set_bits_q     <= RST_SET_BITS;
			ways_in_use_q  <= RST_WAYS_IN_USE;
			miss_penalty_q <= RST_MISS_PENALTY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS:  offset_bits_q  <= cfg_data[3:0];
				CFG_SET_BITS:     set_bits_q     <= cfg_data[3:0];
				CFG_WAYS_IN_USE:  ways_in_use_q  <= cfg_data[3:0];
				CFG_MISS_PENALTY: miss_penalty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// split the address and clamp the configured geometry
	always_comb begin
		b_in     = (offset_bits_q > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_bits_q;
		s_in     = (set_bits_q > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_q;
		sb_in    = 6'(b_in) + 6'(s_in);
		addr_m   = address & ADDR_MASK;
		set_mask = 8'((9'd1 << s_in) - 9'd1);
		if (ways_in_use_q == 4'd0) begin
			nw_in = WCNT_W'(1);
		end else if (5'(ways_in_use_q) > 5'(MAX_WAYS)) begin
			nw_in = WCNT_W'(MAX_WAYS);
		end else begin
			nw_in = WCNT_W'(ways_in_use_q);
		end
	end

	assign set_wraps = (CMP_W'(set_q) >= CMP_W'(MAX_SETS));
	assign last_way  = ((way_q + 1'b1) == nw_q);
	assign final_way = hit_q ? hit_way_q : vic_way_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_REDUCE;
			ST_REDUCE: if (!set_wraps) state_d = ST_READ;
			ST_READ:   state_d = ST_CMP;
			ST_CMP:    state_d = last_way ? ST_UPDATE : ST_READ;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_ctl.rd_en  = (state_q == ST_READ);
		mem_ctl.wr_en  = (state_q == ST_UPDATE);
		mem_ctl.tag_we = (state_q == ST_UPDATE) && !hit_q;
		mem_addr = base_q + LINE_W'((state_q == ST_UPDATE) ? final_way
			: way_q[WAY_W-1:0]);
		wr_state.valid = 1'b1;
		wr_state.dirty = (is_write_q == REQ_WRITE) || (hit_q && hit_dirty_q);
		wr_state.stamp = stamp_q;
		block_bytes    = 13'(1) << b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					is_write_q <= req_type;
					stamp_q    <= access_stamp;
					b_q        <= b_in;
					nw_q       <= nw_in;
					set_q      <= 8'(addr_m >> b_in) & set_mask;
					tag_q      <= (sb_in >= 6'd32) ? 32'd0 : (addr_m >> sb_in);
				end
			end
			ST_REDUCE: begin
				if (set_wraps) begin
					set_q <= set_q - 8'(MAX_SETS);
				end else begin
					base_q      <= LINE_W'(32'(set_q) * 32'(MAX_WAYS));
					way_q       <= '0;
					hit_q       <= 1'b0;
					vic_stop_q  <= 1'b0;
				end
			end
			ST_READ: ;
			ST_CMP: begin
				if (!hit_q && ev.match) begin
					hit_q       <= 1'b1;
					hit_way_q   <= way_q[WAY_W-1:0];
					hit_dirty_q <= rd_state.dirty;
					hit_stamp_q <= rd_state.stamp;
				end
				if (ev.take) begin
					vic_way_q   <= way_q[WAY_W-1:0];
					vic_valid_q <= rd_state.valid;
					vic_dirty_q <= rd_state.dirty;
					vic_stamp_q <= rd_state.stamp;
					vic_tag_q   <= rd_tag;
				end
				if (ev.stop) begin
					vic_stop_q <= 1'b1;
				end
				way_q <= way_q + 1'b1;
			end
			ST_UPDATE: begin
				set_index_q  <= set_q;
				tag_value_q  <= tag_q;
				way_chosen_q <= 3'(final_way);
				if (hit_q) begin
					outcome_q            <= OUT_HIT;
					old_tag_q            <= tag_q;
					old_valid_q          <= 1'b1;
					old_dirty_q          <= hit_dirty_q;
					old_stamp_q          <= hit_stamp_q;
					access_cycles_q      <= 17'd1;
					bytes_fetched_q      <= '0;
					bytes_written_back_q <= '0;
				end else begin
					old_tag_q       <= vic_valid_q ? vic_tag_q : 32'd0;
					old_valid_q     <= vic_valid_q;
					old_dirty_q     <= vic_dirty_q;
					old_stamp_q     <= vic_stamp_q;
					bytes_fetched_q <= block_bytes;
					if (vic_dirty_q) begin
						outcome_q            <= OUT_DIRTY_MISS;
						access_cycles_q      <= 17'd1 + {miss_penalty_q, 1'b0};
						bytes_written_back_q <= block_bytes;
					end else begin
						outcome_q            <= OUT_CLEAN_MISS;
						access_cycles_q      <= 17'd1 + 17'(miss_penalty_q);
						bytes_written_back_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign done               = done_q;
	assign set_index          = set_index_q;
	assign tag_value          = tag_value_q;
	assign way_chosen         = way_chosen_q;
	assign outcome            = outcome_q;
	assign old_tag            = old_tag_q;
	assign old_valid          = old_valid_q;
	assign old_dirty          = old_dirty_q;
	assign old_stamp          = old_stamp_q;
	assign access_cycles      = access_cycles_q;
	assign bytes_fetched      = bytes_fetched_q;
	assign bytes_written_back = bytes_written_back_q;

endmodule

// ===== verif/tb.sv =====
module tb;
	import salc_pkg::*;

	localparam logic REQ_READ       = ~REQ_WRITE;
	localparam int   WAYS           = 8;
	localparam int   LINES          = 256 * WAYS;
	localparam int   SETTLE         = 24;
	localparam int   WATCHDOG_LIMIT = 12000;
	localparam int   PHASES         = 8;
	localparam int   PHASE_ITEMS    = 54;

	typedef enum logic {ROW_CFG, ROW_ACCESS} row_kind_t;

	typedef struct packed {
		logic [7:0]  set_idx;
		logic [31:0] tag;
		logic [2:0]  way;
		logic [1:0]  outc;
		logic [31:0] otag;
		logic        ov;
		logic        od;
		logic [31:0] ostamp;
		logic [16:0] cyc;
		logic [12:0] fet;
		logic [12:0] wb;
	} cache_access_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        rt;
		logic [31:0] addr;
		logic [31:0] stamp;
		logic        fixed;
		logic [1:0]  outc;
		logic [2:0]  way;
		logic [16:0] cyc;
		logic [12:0] fet;
		logic [12:0] wb;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        req_type = 1'b0;
	logic [31:0] address = '0;
	logic [31:0] access_stamp = '0;
	logic        done;
	logic [7:0]  set_index;
	logic [31:0] tag_value;
	logic [2:0]  way_chosen;
	logic [1:0]  outcome;
	logic [31:0] old_tag;
	logic        old_valid;
	logic        old_dirty;
	logic [31:0] old_stamp;
	logic [16:0] access_cycles;
	logic [12:0] bytes_fetched;
	logic [12:0] bytes_written_back;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic        fixed_on = 1'b0;
	logic [1:0]  fixed_outcome = '0;
	logic [2:0]  fixed_way = '0;
	logic [16:0] fixed_cycles = '0;
	logic [12:0] fixed_fetch = '0;
	logic [12:0] fixed_wback = '0;

	logic [3:0]  cur_offset;
	logic [3:0]  cur_sets;
	logic [3:0]  cur_ways;
	logic [15:0] cur_penalty;
	logic [31:0] tag_ram [LINES];
	logic        valid_bits [LINES];
	logic        dirty_bits [LINES];
	logic [31:0] lru_stamp [LINES];

	cache_access_t pending_accesses[$];
	cache_access_t want;
	cache_access_t pred;
	plan_row_t     directed_rows[$];

	int errors = 0;
	int n_requests = 0;
	int n_hits = 0;
	int n_clean = 0;
	int n_dirty = 0;
	int n_cfg = 0;
	int idle_cycles = 0;

	set_assoc_cache_lru_model dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		errors++;
		if (errors <= 50)
			$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, exp_val);
	endtask

	function automatic cache_access_t cache_lookup(logic wr, logic [31:0] addr,
			logic [31:0] stamp);
		cache_access_t r;
		int b, s, nw, base, way, i;
		logic hit, stop;
		logic [31:0] set_no, tag;
		b = (cur_offset > OFFSET_BITS_MAX) ? int'(OFFSET_BITS_MAX) : int'(cur_offset);
		s = (cur_sets > SET_BITS_MAX) ? int'(SET_BITS_MAX) : int'(cur_sets);
		nw = (cur_ways == 0) ? 1 : ((cur_ways > WAYS) ? WAYS : int'(cur_ways));
		set_no = (addr >> b) & ((32'd1 << s) - 32'd1);
		tag = (b + s >= 32) ? 32'd0 : (addr >> (b + s));
		base = set_no * WAYS;
		hit = 1'b0;
		way = 0;
		for (i = 0; i < nw; i++) begin
			if (!hit && valid_bits[base + i] && tag_ram[base + i] == tag) begin
				hit = 1'b1;
				way = i;
			end
		end
		if (!hit) begin
			stop = 1'b0;
			for (i = 0; i < nw; i++) begin
				if (!stop) begin
					if (!valid_bits[base + i]) begin
						way = i;
						stop = 1'b1;
					end else if (lru_stamp[base + way] > lru_stamp[base + i]) begin
						way = i;
					end
				end
			end
		end
		r.set_idx = set_no[7:0];
		r.tag = tag;
		r.way = way[2:0];
		r.ov = valid_bits[base + way];
		r.od = dirty_bits[base + way];
		r.otag = r.ov ? tag_ram[base + way] : 32'd0;
		r.ostamp = lru_stamp[base + way];
		if (hit) begin
			r.outc = OUT_HIT;
			r.cyc = 17'd1;
			r.fet = '0;
			r.wb = '0;
		end else begin
			r.fet = 13'd1 << b;
			if (r.od) begin
				r.outc = OUT_DIRTY_MISS;
				r.cyc = 17'd1 + {cur_penalty, 1'b0};
				r.wb = r.fet;
			end else begin
				r.outc = OUT_CLEAN_MISS;
				r.cyc = 17'd1 + {1'b0, cur_penalty};
				r.wb = '0;
			end
			tag_ram[base + way] = tag;
			valid_bits[base + way] = 1'b1;
			dirty_bits[base + way] = 1'b0;
		end
		lru_stamp[base + way] = stamp;
		if (wr == REQ_WRITE)
			dirty_bits[base + way] = 1'b1;
		return r;
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (pending_accesses.size() == 0) begin
				report_mismatch("result with no request waiting", 32'd0, 32'd0);
			end else begin
				want = pending_accesses.pop_front();
				case (want.outc)
					OUT_HIT:        n_hits++;
					OUT_CLEAN_MISS: n_clean++;
					default:        n_dirty++;
				endcase
				if (set_index !== want.set_idx)
					report_mismatch("set_index", set_index, want.set_idx);
				if (tag_value !== want.tag)
					report_mismatch("tag_value", tag_value, want.tag);
				if (way_chosen !== want.way)
					report_mismatch("way_chosen", way_chosen, want.way);
				if (outcome !== want.outc)
					report_mismatch("outcome", outcome, want.outc);
				if (old_tag !== want.otag)
					report_mismatch("old_tag", old_tag, want.otag);
				if (old_valid !== want.ov)
					report_mismatch("old_valid", old_valid, want.ov);
				if (old_dirty !== want.od)
					report_mismatch("old_dirty", old_dirty, want.od);
				if (old_stamp !== want.ostamp)
					report_mismatch("old_stamp", old_stamp, want.ostamp);
				if (access_cycles !== want.cyc)
					report_mismatch("access_cycles", access_cycles, want.cyc);
				if (bytes_fetched !== want.fet)
					report_mismatch("bytes_fetched", bytes_fetched, want.fet);
				if (bytes_written_back !== want.wb)
					report_mismatch("bytes_written_back", bytes_written_back, want.wb);
			end
		end
		if (start && !busy) begin
			pred = cache_lookup(req_type, address, access_stamp);
			if (fixed_on) begin
				pred.outc = fixed_outcome;
				pred.way = fixed_way;
				pred.cyc = fixed_cycles;
				pred.fet = fixed_fetch;
				pred.wb = fixed_wback;
			end
			pending_accesses.push_back(pred);
			n_requests++;
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OFFSET_BITS:  cur_offset = cfg_data[3:0];
				CFG_SET_BITS:     cur_sets = cfg_data[3:0];
				CFG_WAYS_IN_USE:  cur_ways = cfg_data[3:0];
				CFG_MISS_PENALTY: cur_penalty = cfg_data;
				default: ;
			endcase
			n_cfg++;
		end
		if (done || (start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic hold_off(int cycles, bit drain);
		if (cycles > 0 || drain) begin
			start <= 1'b0;
			if (drain)
				while (pending_accesses.size() != 0)
					@(posedge clk);
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic issue_access(logic rt, logic [31:0] addr, logic [31:0] stamp, logic fixed,
			logic [1:0] outc, logic [2:0] way, logic [16:0] cyc, logic [12:0] fet,
			logic [12:0] wb);
		start <= 1'b1;
		req_type <= rt;
		address <= addr;
		access_stamp <= stamp;
		fixed_on <= fixed;
		fixed_outcome <= outc;
		fixed_way <= way;
		fixed_cycles <= cyc;
		fixed_fetch <= fet;
		fixed_wback <= wb;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		hold_off(SETTLE, 1'b1);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_cfg(logic [1:0] idx, logic [15:0] data);
		plan_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.addr = {30'd0, idx};
		row.stamp = {16'd0, data};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_access(logic rt, logic [31:0] addr, logic [31:0] stamp,
			logic fixed, logic [1:0] outc, logic [2:0] way, logic [16:0] cyc,
			logic [12:0] fet, logic [12:0] wb);
		plan_row_t row;
		row.kind = ROW_ACCESS;
		row.rt = rt;
		row.addr = addr;
		row.stamp = stamp;
		row.fixed = fixed;
		row.outc = outc;
		row.way = way;
		row.cyc = cyc;
		row.fet = fet;
		row.wb = wb;
		directed_rows.push_back(row);
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		plan_row_t   row;
		logic [31:0] tag_pool [12];
		logic [31:0] set_pool [3];
		logic [31:0] addr;
		logic [31:0] stamp_ctr;
		logic [15:0] junk;
		logic [3:0]  off_v, set_v, ways_v;
		logic [15:0] pen_v;
		int eb, es, enw, n_tags, n_sets, gap, p, k, i;
		bit no_gaps;

		cur_offset = RST_OFFSET_BITS;
		cur_sets = RST_SET_BITS;
		cur_ways = RST_WAYS_IN_USE;
		cur_penalty = RST_MISS_PENALTY;
		for (i = 0; i < LINES; i++) begin
			tag_ram[i] = '0;
			valid_bits[i] = 1'b0;
			dirty_bits[i] = 1'b0;
			lru_stamp[i] = '0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_access(REQ_READ, 32'h0000_0000, 32'd1, 1'b1, OUT_CLEAN_MISS, 3'd0, 17'd101, 13'd32,
			13'd0);
		add_access(REQ_WRITE, 32'h0000_0000, 32'd2, 1'b1, OUT_HIT, 3'd0, 17'd1, 13'd0, 13'd0);
		add_access(REQ_READ, 32'h0000_0200, 32'd3, 1'b1, OUT_CLEAN_MISS, 3'd1, 17'd101, 13'd32,
			13'd0);
		add_access(REQ_READ, 32'h0000_0400, 32'd4, 1'b1, OUT_DIRTY_MISS, 3'd0, 17'd201, 13'd32,
			13'd32);
		add_access(REQ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, OUT_CLEAN_MISS, 3'd0, 17'd101,
			13'd32, 13'd0);
		add_access(REQ_READ, 32'hFFFF_FFFF, 32'd0, 1'b1, OUT_HIT, 3'd0, 17'd1, 13'd0, 13'd0);
		add_cfg(CFG_OFFSET_BITS, 16'hFFFF);
		add_cfg(CFG_SET_BITS, 16'hFFFF);
		add_cfg(CFG_WAYS_IN_USE, 16'hFFF0);
		add_cfg(CFG_MISS_PENALTY, 16'hFFFF);
		add_access(REQ_READ, 32'hFFFF_FFFF, 32'd5, 1'b1, OUT_CLEAN_MISS, 3'd0, 17'd65536,
			13'd4096, 13'd0);
		add_access(REQ_WRITE, 32'h0000_0000, 32'd6, 1'b1, OUT_CLEAN_MISS, 3'd0, 17'd65536,
			13'd4096, 13'd0);
		add_access(REQ_WRITE, 32'h0000_1000, 32'd7, 1'b1, OUT_CLEAN_MISS, 3'd0, 17'd65536,
			13'd4096, 13'd0);
		add_access(REQ_READ, 32'h0000_0000, 32'd8, 1'b1, OUT_HIT, 3'd0, 17'd1, 13'd0, 13'd0);
		add_access(REQ_READ, 32'h0030_0000, 32'd9, 1'b1, OUT_DIRTY_MISS, 3'd0, 17'd131071,
			13'd4096, 13'd4096);
		add_cfg(CFG_OFFSET_BITS, 16'h0005);
		add_cfg(CFG_SET_BITS, 16'h0004);
		add_cfg(CFG_WAYS_IN_USE, 16'h0002);
		add_cfg(CFG_MISS_PENALTY, 16'd100);
		add_access(REQ_READ, 32'h0000_0200, 32'd10, 1'b1, OUT_HIT, 3'd1, 17'd1, 13'd0, 13'd0);
		add_access(REQ_READ, 32'hFFFF_FFFF, 32'd11, 1'b1, OUT_HIT, 3'd0, 17'd1, 13'd0, 13'd0);
		add_cfg(CFG_OFFSET_BITS, 16'h0000);
		add_cfg(CFG_SET_BITS, 16'h0000);
		add_cfg(CFG_WAYS_IN_USE, 16'h000F);
		add_cfg(CFG_MISS_PENALTY, 16'h0000);
		add_access(REQ_WRITE, 32'hFFFF_FFFF, 32'd12, 1'b0, OUT_HIT, 3'd0, 17'd0, 13'd0, 13'd0);
		add_access(REQ_WRITE, 32'h0000_0000, 32'd12, 1'b0, OUT_HIT, 3'd0, 17'd0, 13'd0, 13'd0);
		add_access(REQ_READ, 32'h1234_5678, 32'd12, 1'b0, OUT_HIT, 3'd0, 17'd0, 13'd0, 13'd0);
		add_access(REQ_READ, 32'hFFFF_FFFF, 32'd13, 1'b0, OUT_HIT, 3'd0, 17'd0, 13'd0, 13'd0);
		add_access(REQ_WRITE, 32'hA5A5_A5A5, 32'd14, 1'b0, OUT_HIT, 3'd0, 17'd0, 13'd0, 13'd0);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				write_reg(row.addr[1:0], row.stamp[15:0]);
			end else begin
				hold_off(rand_gap(), 1'b0);
				issue_access(row.rt, row.addr, row.stamp, row.fixed, row.outc, row.way, row.cyc,
					row.fet, row.wb);
			end
		end

		stamp_ctr = 32'd100;
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin off_v = 4'd0; set_v = 4'd0; ways_v = 4'd1; pen_v = 16'd0; end
				1: begin off_v = 4'd12; set_v = 4'd8; ways_v = 4'd8; pen_v = 16'hFFFF; end
				2: begin off_v = 4'd15; set_v = 4'd15; ways_v = 4'd0; pen_v = 16'($urandom); end
				3: begin off_v = 4'd2; set_v = 4'd1; ways_v = 4'd15; pen_v = 16'($urandom); end
				default: begin
					off_v = 4'($urandom_range(0, 15));
					set_v = 4'($urandom_range(0, 15));
					ways_v = 4'($urandom_range(0, 15));
					pen_v = 16'($urandom);
				end
			endcase
			junk = 16'($urandom);
			write_reg(CFG_OFFSET_BITS, {junk[15:4], off_v});
			junk = 16'($urandom);
			write_reg(CFG_SET_BITS, {junk[15:4], set_v});
			junk = 16'($urandom);
			write_reg(CFG_WAYS_IN_USE, {junk[15:4], ways_v});
			write_reg(CFG_MISS_PENALTY, pen_v);

			eb = (off_v > OFFSET_BITS_MAX) ? int'(OFFSET_BITS_MAX) : int'(off_v);
			es = (set_v > SET_BITS_MAX) ? int'(SET_BITS_MAX) : int'(set_v);
			enw = (ways_v == 0) ? 1 : ((ways_v > WAYS) ? WAYS : int'(ways_v));
			n_tags = enw + $urandom_range(0, 3);
			n_sets = $urandom_range(1, 3);
			for (i = 0; i < n_tags; i++)
				tag_pool[i] = $urandom;
			for (i = 0; i < n_sets; i++)
				set_pool[i] = $urandom_range(0, (1 << es) - 1);
			no_gaps = ($urandom_range(0, 3) == 0);

			for (k = 0; k < PHASE_ITEMS; k++) begin
				gap = no_gaps ? 0 : rand_gap();
				if ($urandom_range(0, 39) == 0)
					hold_off(gap + 1, 1'b1);
				else
					hold_off(gap, 1'b0);
				if ($urandom_range(0, 99) < 85)
					addr = (tag_pool[$urandom_range(0, n_tags - 1)] << (eb + es))
						| (set_pool[$urandom_range(0, n_sets - 1)] << eb)
						| ($urandom & ((32'd1 << eb) - 32'd1));
				else
					addr = $urandom;
				if ($urandom_range(0, 99) < 3)
					stamp_ctr = $urandom;
				else
					stamp_ctr = stamp_ctr + $urandom_range(0, 2);
				issue_access(1'($urandom_range(0, 1)), addr, stamp_ctr, 1'b0, OUT_HIT, 3'd0,
					17'd0, 13'd0, 13'd0);
			end
		end

		hold_off(40, 1'b1);
		$display("covered %0d requests: %0d hits, %0d clean misses, %0d dirty misses",
			n_requests, n_hits, n_clean, n_dirty);
		$display("across %0d register writes and %0d geometry phases", n_cfg, PHASES + 3);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
src/salc_pkg.sv
src/salc_way_eval.sv
src/salc_line_mem.sv
src/set_assoc_cache_lru_model.sv
verif/tb.sv
